[hdl/dps_pkg.sv]
// Shared types and constants for the distribution pairwise sum block.
// No dependencies; every other file of the block but dps_ram uses this package.
`default_nettype none

package dps_pkg;

  localparam int VAL_W      = 32;
  localparam int CNT_W      = 16;
  localparam int SUM_CNT_W  = 32;
  localparam int PAIR_CNT_W = CNT_W + 1;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMBINE    = 2'd2;

  // One entry of the sorted result row.
  typedef struct packed {
    logic                 valid;
    logic [VAL_W-1:0]     value;
    logic [SUM_CNT_W-1:0] count;
  } ent_t;

  // One pair offered to the row for insertion.
  typedef struct packed {
    logic                  valid;
    logic [VAL_W-1:0]      value;
    logic [PAIR_CNT_W-1:0] count;
  } pair_t;

  // Controls broadcast to every cell of the row.
  typedef struct packed {
    logic clear;
    logic shift_out;
    logic insert;
    logic any_eq;
    logic full;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/dps_if.sv]
// Valid/ready channel interfaces for the request and result sides.
// Depends on dps_pkg for the field widths.
`default_nettype none

interface dps_in_if;
  logic                          valid;
  logic                          ready;
  logic [dps_pkg::OP_W-1:0]      operation;
  logic signed [dps_pkg::VAL_W-1:0] entry_value;
  logic [dps_pkg::CNT_W-1:0]     entry_count;

  modport source (output valid, output operation, output entry_value,
                  output entry_count, input ready);
  modport sink   (input valid, input operation, input entry_value,
                  input entry_count, output ready);
endinterface

interface dps_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dps_pkg::VAL_W-1:0] sum_value;
  logic [dps_pkg::SUM_CNT_W-1:0]    sum_count;
  logic                             last_entry;
  logic                             table_empty;
  logic                             table_overflow;

  modport source (output valid, output sum_value, output sum_count,
                  output last_entry, output table_empty,
                  output table_overflow, input ready);
  modport sink   (input valid, input sum_value, input sum_count,
                  input last_entry, input table_empty,
                  input table_overflow, output ready);
endinterface

`default_nettype wire

[hdl/distribution_pairwise_sum.sv]
// Top level of the distribution pairwise sum block: side tables, pair
// generator, sorted row of cells and result emission.
// Depends on dps_pkg, dps_if, dps_ram and dps_cell.
//
// Usage: each request on in_ch carries an operation. A load-left or
// load-right request appends (entry_value, entry_count) to that side and is
// taken whenever the block is idle; loads into a full side are ignored, as is operation 3.
// A combine request starts a run: the generator walks every left/right pair,
// one pair per cycle, through a two-stage pipeline (side RAM read, then the
// saturating sums) into the row of RESULT_DEPTH cells, which inserts or
// merges one pair per cycle. A side that is empty acts as a single zero
// entry. After the pipeline drains, the row shifts out on out_ch, one
// result per cycle from the head cell, ascending by value, last_entry on
// the final one; an empty row gives one result with table_empty set.
// A combine therefore holds in_ch.ready low through the pair walk, the
// drain and the emission, until the out_ch side has taken the last result.
// When out_ch.ready is low the head result simply holds. Reset empties
// both sides and the row; no clearing pass is needed.
`default_nettype none

module distribution_pairwise_sum #(
  parameter int SIDE_DEPTH   = 8,
  parameter int RESULT_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dps_in_if.sink    in_ch,
  dps_out_if.source out_ch
);
  import dps_pkg::*;

  localparam int SIDE_AW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int LEN_W   = $clog2(SIDE_DEPTH + 1);
  localparam int ROW_W   = VAL_W + CNT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     llen_r, llen_nxt, rlen_r, rlen_nxt;
  logic [SIDE_AW-1:0]   llast_r, llast_nxt, rlast_r, rlast_nxt;
  logic                 lzero_r, lzero_nxt, rzero_r, rzero_nxt;
  logic [SIDE_AW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic                 rd_v_r, rd_v_nxt;
  pair_t                pair_r, pair_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 in_acc, out_acc;
  logic                 lwe, rwe;
  logic [ROW_W-1:0]     wdata, ldata, rdata;
  logic [VAL_W-1:0]     lval, rval;
  logic [CNT_W-1:0]     lcnt, rcnt;
  logic [VAL_W:0]       vsum;

  cell_ctrl_t           ctrl;
  ent_t                 ent_q [RESULT_DEPTH+1];
  logic [RESULT_DEPTH-1:0] less_v, eq_v, valid_v;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Side tables.
  assign wdata = {in_ch.entry_value, in_ch.entry_count};
  assign lwe = in_acc && (in_ch.operation == OP_LOAD_LEFT) &&
               (llen_r < LEN_W'(SIDE_DEPTH));
  assign rwe = in_acc && (in_ch.operation == OP_LOAD_RIGHT) &&
               (rlen_r < LEN_W'(SIDE_DEPTH));

  dps_ram #(.WIDTH(ROW_W), .DEPTH(SIDE_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (llen_r[SIDE_AW-1:0]),
    .wdata (wdata),
    .raddr (i_r),
    .rdata (ldata)
  );

  dps_ram #(.WIDTH(ROW_W), .DEPTH(SIDE_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (rwe),
    .waddr (rlen_r[SIDE_AW-1:0]),
    .wdata (wdata),
    .raddr (j_r),
    .rdata (rdata)
  );

  // Pair stage: an empty side reads as a zero entry, which is the identity.
  always_comb begin
    lval = lzero_r ? '0 : ldata[ROW_W-1:CNT_W];
    lcnt = lzero_r ? '0 : ldata[CNT_W-1:0];
    rval = rzero_r ? '0 : rdata[ROW_W-1:CNT_W];
    rcnt = rzero_r ? '0 : rdata[CNT_W-1:0];
    vsum = {lval[VAL_W-1], lval} + {rval[VAL_W-1], rval};
    pair_nxt.valid = rd_v_r;
    pair_nxt.count = {1'b0, lcnt} + {1'b0, rcnt};
    if (vsum[VAL_W] != vsum[VAL_W-1]) begin
      pair_nxt.value = vsum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                   : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      pair_nxt.value = vsum[VAL_W-1:0];
    end
  end

  // Row of cells.
  assign ctrl.clear     = in_acc && (in_ch.operation == OP_COMBINE);
  assign ctrl.shift_out = (state_r == ST_EMIT) && out_acc;
  assign ctrl.insert    = pair_r.valid && (pair_r.count != '0);
  assign ctrl.any_eq    = |eq_v;
  assign ctrl.full      = valid_v[RESULT_DEPTH-1];

  assign ent_q[RESULT_DEPTH] = '0;

  for (genvar k = 0; k < RESULT_DEPTH; k++) begin : g_cell
    ent_t prev_ent;
    logic prev_less;
    if (k == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_less = 1'b1;
    end else begin : g_body
      assign prev_ent  = ent_q[k-1];
      assign prev_less = less_v[k-1];
    end

    dps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .pair      (pair_r),
      .prev_ent  (prev_ent),
      .prev_less (prev_less),
      .next_ent  (ent_q[k+1]),
      .ent       (ent_q[k]),
      .less      (less_v[k]),
      .eq        (eq_v[k])
    );

    assign valid_v[k] = ent_q[k].valid;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    llen_nxt  = llen_r;
    rlen_nxt  = rlen_r;
    llast_nxt = llast_r;
    rlast_nxt = rlast_r;
    lzero_nxt = lzero_r;
    rzero_nxt = rzero_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    rd_v_nxt  = 1'b0;
    ovf_nxt   = ovf_r;
    if (lwe) begin
      llen_nxt = llen_r + LEN_W'(1);
    end
    if (rwe) begin
      rlen_nxt = rlen_r + LEN_W'(1);
    end
    if (ctrl.insert && !ctrl.any_eq && ctrl.full) begin
      ovf_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.clear) begin
          lzero_nxt = (llen_r == '0);
          rzero_nxt = (rlen_r == '0);
          llast_nxt = (llen_r == '0) ? '0 : SIDE_AW'(llen_r - LEN_W'(1));
          rlast_nxt = (rlen_r == '0) ? '0 : SIDE_AW'(rlen_r - LEN_W'(1));
          llen_nxt  = '0;
          rlen_nxt  = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_v_nxt = 1'b1;
        if (j_r == rlast_r) begin
          j_nxt = '0;
          if (i_r == llast_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + SIDE_AW'(1);
          end
        end else begin
          j_nxt = j_r + SIDE_AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !pair_r.valid) begin
          state_nxt = ent_q[0].valid ? ST_EMIT : ST_EMPTY;
        end
      end
      ST_EMIT: begin
        if (out_acc && !ent_q[1].valid) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      llen_r       <= '0;
      rlen_r       <= '0;
      rd_v_r       <= 1'b0;
      pair_r.valid <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      llen_r       <= llen_nxt;
      rlen_r       <= rlen_nxt;
      rd_v_r       <= rd_v_nxt;
      pair_r.valid <= pair_nxt.valid;
      ovf_r        <= ovf_nxt;
    end
    llast_r      <= llast_nxt;
    rlast_r      <= rlast_nxt;
    lzero_r      <= lzero_nxt;
    rzero_r      <= rzero_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    pair_r.value <= pair_nxt.value;
    pair_r.count <= pair_nxt.count;
  end

  // Ports.
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    out_ch.valid          = (state_r == ST_EMIT) || (state_r == ST_EMPTY);
    out_ch.sum_value      = '0;
    out_ch.sum_count      = '0;
    out_ch.last_entry     = 1'b1;
    out_ch.table_empty    = 1'b1;
    out_ch.table_overflow = 1'b0;
    if (state_r == ST_EMIT) begin
      out_ch.sum_value      = ent_q[0].value;
      out_ch.sum_count      = ent_q[0].count;
      out_ch.last_entry     = !ent_q[1].valid;
      out_ch.table_empty    = 1'b0;
      out_ch.table_overflow = ovf_r;
    end
  end

  // Checks.
  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_v} + (RESULT_DEPTH + 1)'(1)))
    else $error("result row has a gap between valid cells");

  a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && ent_q[1].valid |->
      ($signed(ent_q[0].value) < $signed(ent_q[1].value)))
    else $error("result row is not in strictly ascending order");

  a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ent_q[0].valid)
    else $error("emitting from an empty head cell");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while a result is pending");

endmodule

`default_nettype wire

[hdl/dps_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/dps_cell.sv]
// One cell of the sorted result row: holds a value and its count, merges
// an equal pair, shifts right to open a gap, shifts left on emission, or clears.
// Depends on dps_pkg.
`default_nettype none

module dps_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dps_pkg::cell_ctrl_t ctrl,
  input  wire dps_pkg::pair_t      pair,
  input  wire dps_pkg::ent_t       prev_ent,
  input  wire logic                prev_less,
  input  wire dps_pkg::ent_t       next_ent,
  output      dps_pkg::ent_t       ent,
  output      logic                less,
  output      logic                eq
);
  import dps_pkg::*;

  ent_t               ent_r;
  ent_t               ent_nxt;
  logic [SUM_CNT_W:0] sum;

  always_comb begin
    less    = ent_r.valid && ($signed(ent_r.value) < $signed(pair.value));
    eq      = ent_r.valid && (ent_r.value == pair.value);
    sum     = {1'b0, ent_r.count} + (SUM_CNT_W + 1)'(pair.count);
    ent_nxt = ent_r;
    priority if (ctrl.clear) begin
      ent_nxt.valid = 1'b0;
    end else if (ctrl.shift_out) begin
      ent_nxt = next_ent;
    end else if (ctrl.insert) begin
      if (eq) begin
        ent_nxt.count = sum[SUM_CNT_W] ? '1 : sum[SUM_CNT_W-1:0];
      end else if (!ctrl.any_eq && !ctrl.full && !less) begin
        // The new value lands in the first cell not below it; the cells
        // after it take their left neighbour's entry.
        if (prev_less) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.value = pair.value;
          ent_nxt.count = SUM_CNT_W'(pair.count);
        end else begin
          ent_nxt = prev_ent;
        end
      end
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.value <= ent_nxt.value;
    ent_r.count <= ent_nxt.count;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for distribution_pairwise_sum.
// Depends on dps_pkg, the dps_in_if/dps_out_if channels and the block itself;
// an internal predictor of the pairwise sum checks every result in order.
`timescale 1ns / 1ps

module tb_top;
  import dps_pkg::*;

  localparam int SIDE_DEPTH   = 8;
  localparam int RESULT_DEPTH = 64;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * RESULT_DEPTH;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_REQS  = 85;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [VAL_W-1:0] sum_value;
    logic [SUM_CNT_W-1:0]    sum_count;
    logic                    last_entry;
    logic                    table_empty;
    logic                    table_overflow;
  } sum_entry_t;

  // Mirrors the side tables and the sorted row, and queues the result
  // entries each combine request should produce.
  class pairwise_sum_scoreboard;
    logic signed [VAL_W-1:0] left_vals[SIDE_DEPTH];
    logic [CNT_W-1:0]        left_cnts[SIDE_DEPTH];
    int                      left_len;
    logic signed [VAL_W-1:0] right_vals[SIDE_DEPTH];
    logic [CNT_W-1:0]        right_cnts[SIDE_DEPTH];
    int                      right_len;
    logic signed [VAL_W-1:0] row_vals[RESULT_DEPTH];
    logic [SUM_CNT_W-1:0]    row_cnts[RESULT_DEPTH];
    int                      row_len;
    logic                    row_overflow;
    sum_entry_t              sums_due[$];
    int                      failures;

    function new();
      left_len = 0;
      right_len = 0;
      row_len = 0;
      row_overflow = 1'b0;
      failures = 0;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function logic signed [VAL_W-1:0] sat_sum(logic signed [VAL_W-1:0] a,
                                              logic signed [VAL_W-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > VAL_MAX) return VAL_MAX[VAL_W-1:0];
      if (s < VAL_MIN) return VAL_MIN[VAL_W-1:0];
      return s[VAL_W-1:0];
    endfunction

    function void add_pair(logic signed [VAL_W-1:0] v, logic [PAIR_CNT_W-1:0] c);
      int pos;
      logic [SUM_CNT_W:0] acc;
      if (c == 0) return;
      pos = 0;
      while (pos < row_len && row_vals[pos] < v) pos++;
      if (pos < row_len && row_vals[pos] == v) begin
        acc = {1'b0, row_cnts[pos]} + (SUM_CNT_W + 1)'(c);
        row_cnts[pos] = acc[SUM_CNT_W] ? '1 : acc[SUM_CNT_W-1:0];
        return;
      end
      if (row_len >= RESULT_DEPTH) begin
        row_overflow = 1'b1;
        return;
      end
      for (int k = row_len; k > pos; k--) begin
        row_vals[k] = row_vals[k-1];
        row_cnts[k] = row_cnts[k-1];
      end
      row_vals[pos] = v;
      row_cnts[pos] = SUM_CNT_W'(c);
      row_len++;
    endfunction

    function void combine();
      sum_entry_t e;
      row_len = 0;
      row_overflow = 1'b0;
      // An empty side behaves as the identity of the pairwise sum.
      if (left_len == 0) begin
        for (int j = 0; j < right_len; j++)
          add_pair(right_vals[j], PAIR_CNT_W'(right_cnts[j]));
      end else if (right_len == 0) begin
        for (int i = 0; i < left_len; i++)
          add_pair(left_vals[i], PAIR_CNT_W'(left_cnts[i]));
      end else begin
        for (int i = 0; i < left_len; i++)
          for (int j = 0; j < right_len; j++)
            add_pair(sat_sum(left_vals[i], right_vals[j]),
                     PAIR_CNT_W'(left_cnts[i]) + PAIR_CNT_W'(right_cnts[j]));
      end
      left_len = 0;
      right_len = 0;
      if (row_len == 0) begin
        e = '{sum_value: '0, sum_count: '0, last_entry: 1'b1, table_empty: 1'b1,
              table_overflow: 1'b0};
        sums_due.push_back(e);
        return;
      end
      for (int i = 0; i < row_len; i++) begin
        e = '{sum_value: row_vals[i], sum_count: row_cnts[i],
              last_entry: (i == row_len - 1), table_empty: 1'b0,
              table_overflow: row_overflow};
        sums_due.push_back(e);
      end
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                               logic [CNT_W-1:0] c);
      case (op)
        OP_LOAD_LEFT: begin
          if (left_len < SIDE_DEPTH) begin
            left_vals[left_len] = v;
            left_cnts[left_len] = c;
            left_len++;
          end
        end
        OP_LOAD_RIGHT: begin
          if (right_len < SIDE_DEPTH) begin
            right_vals[right_len] = v;
            right_cnts[right_len] = c;
            right_len++;
          end
        end
        OP_COMBINE: combine();
        default: ;
      endcase
    endfunction

    function void check_result(sum_entry_t got);
      sum_entry_t want;
      if (sums_due.size() == 0) begin
        $error("unexpected result: sum_value %0d sum_count %0d", got.sum_value,
               got.sum_count);
        failures++;
        return;
      end
      want = sums_due.pop_front();
      if (got.sum_value !== want.sum_value) begin
        $error("sum_value: expected %0d, got %0d", want.sum_value, got.sum_value);
        failures++;
      end
      if (got.sum_count !== want.sum_count) begin
        $error("sum_count: expected %0d, got %0d", want.sum_count, got.sum_count);
        failures++;
      end
      if (got.last_entry !== want.last_entry) begin
        $error("last_entry: expected %0b, got %0b", want.last_entry, got.last_entry);
        failures++;
      end
      if (got.table_empty !== want.table_empty) begin
        $error("table_empty: expected %0b, got %0b", want.table_empty,
               got.table_empty);
        failures++;
      end
      if (got.table_overflow !== want.table_overflow) begin
        $error("table_overflow: expected %0b, got %0b", want.table_overflow,
               got.table_overflow);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  dps_in_if  in_ch();
  dps_out_if out_ch();

  distribution_pairwise_sum #(
    .SIDE_DEPTH  (SIDE_DEPTH),
    .RESULT_DEPTH(RESULT_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pairwise_sum_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit long_hold_request = 1'b0;
  int requests_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                              logic [CNT_W-1:0] c);
    while (idle_on && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_value <= v;
    in_ch.entry_count <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, v, c);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(int mode);
    case (mode)
      // Whole-unit grid values, so that pairs often land on the same sum.
      0: return VAL_W'((int'($urandom_range(0, 8)) - 4) * 65536);
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7FFFFFFF - VAL_W'($urandom_range(0, 3));
          1: return 32'sh80000000 + VAL_W'($urandom_range(0, 3));
          2: return 32'sh40000000 + VAL_W'($urandom_range(0, 65535));
          default: return 32'shC0000000 - VAL_W'($urandom_range(0, 65535));
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0, 1: return CNT_W'($urandom_range(0, 2));
      2: return '1;
      default: return CNT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_side_size();
    if ($urandom_range(99) < 12) return $urandom_range(SIDE_DEPTH, SIDE_DEPTH + 1);
    return $urandom_range(0, 5);
  endfunction

  // Loads both sides in a random interleaving, then asks for the combine.
  task automatic run_sequence(int n_left, int n_right, int vmode);
    while (n_left + n_right > 0) begin
      if (n_right == 0 || (n_left > 0 && $urandom_range(1) == 0)) begin
        send_request(OP_LOAD_LEFT, pick_value(vmode), pick_count());
        n_left--;
      end else begin
        send_request(OP_LOAD_RIGHT, pick_value(vmode), pick_count());
        n_right--;
      end
    end
    send_request(OP_COMBINE, $urandom, CNT_W'($urandom));
  endtask

  initial begin : result_sink
    int hold_left;
    sum_entry_t got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{sum_value: out_ch.sum_value, sum_count: out_ch.sum_count,
                last_entry: out_ch.last_entry, table_empty: out_ch.table_empty,
                table_overflow: out_ch.table_overflow};
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 13);
      end
    end
  end

  initial begin : stimulus
    int seq_no;
    int n_left;
    int n_right;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_LOAD_LEFT;
    in_ch.entry_value <= '0;
    in_ch.entry_count <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both sides empty gives the single empty-table result.
    send_request(OP_COMBINE, '0, '0);
    // Left side alone passes through; a zero count is dropped.
    send_request(OP_LOAD_LEFT, 32'sh7FFFFFFF, 16'hFFFF);
    send_request(OP_LOAD_LEFT, 32'sh80000000, 16'h0001);
    send_request(OP_LOAD_LEFT, 32'sh00000000, 16'h0000);
    send_request(OP_COMBINE, '1, '1);
    // Right side alone, with a repeated value that must merge.
    send_request(OP_LOAD_RIGHT, -32'sd1, 16'd5);
    send_request(OP_LOAD_RIGHT, -32'sd1, 16'd7);
    send_request(OP_COMBINE, '0, '0);
    // Max+max saturates; min+min has a zero count; the mixed sums merge at -1.
    send_request(OP_LOAD_LEFT, 32'sh7FFFFFFF, 16'hFFFF);
    send_request(OP_LOAD_LEFT, 32'sh80000000, 16'h0000);
    send_request(OP_LOAD_RIGHT, 32'sh7FFFFFFF, 16'hFFFF);
    send_request(OP_LOAD_RIGHT, 32'sh80000000, 16'h0000);
    send_request(OP_COMBINE, '0, '0);
    // The unused operation code must be ignored.
    send_request(OP_UNUSED, 32'sh5A5A5A5A, 16'hA5A5);
    // Nine loads into one side: the last is dropped, the rest come out sorted.
    for (int k = 0; k < SIDE_DEPTH + 1; k++)
      send_request(OP_LOAD_LEFT, VAL_W'((SIDE_DEPTH - k) * 65536), CNT_W'(k + 1));
    send_request(OP_COMBINE, '0, '0);

    requests_sent = 0;
    seq_no = 0;
    while (requests_sent < RANDOM_REQS) begin
      idle_on = !(requests_sent >= 45 && requests_sent < 75);
      if (seq_no == 4) begin
        // Hold the result side off while full tables are loaded and combined.
        long_hold_request = 1'b1;
        run_sequence(SIDE_DEPTH, SIDE_DEPTH, 2);
      end else if ($urandom_range(99) < 80) begin
        n_left = pick_side_size();
        n_right = pick_side_size();
        run_sequence(n_left, n_right, $urandom_range(2));
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(OP_W'($urandom_range(3)), pick_value($urandom_range(2)),
                       pick_count());
      end
      seq_no++;
    end
    send_request(OP_COMBINE, '0, '0);
    idle_on = 1'b1;
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/dps_pkg.sv
hdl/dps_if.sv
hdl/dps_ram.sv
hdl/dps_cell.sv
hdl/distribution_pairwise_sum.sv
dv/tb_top.sv
